// ===== rtl/cqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular queue with dump: shared package
// Field widths, operation and result codes, and reset constants used by the
// queue core and its storage.
// ----------------------------------------------------------------------------
package cqd_pkg;

	localparam int VALUE_W      = 32;
	localparam int SLOT_COUNT_W = 5;
	localparam int OP_W         = 2;
	localparam int KIND_W       = 2;
	localparam int DEPTH_DEF    = 16;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [KIND_W-1:0] kind_t;

	// Operation codes of a request.
	localparam op_t OP_ENQ   = 2'd0;
	localparam op_t OP_DEQ   = 2'd1;
	localparam op_t OP_PRINT = 2'd2;

	// Result kinds.
	localparam kind_t KIND_PRINT     = 2'd0;
	localparam kind_t KIND_OVERFLOW  = 2'd1;
	localparam kind_t KIND_UNDERFLOW = 2'd2;

	localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 5'd16;

endpackage

// ===== rtl/circular_queue_with_dump_core.sv =====
// ----------------------------------------------------------------------------
// Circular queue with dump: top level
// Ring buffer over a configurable number of slots, with slot dumps on print
// and on overflow, an underflow notice, and a halt on either error.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Enqueue and dequeue requests give no result and leave busy low, so they
// can be issued back to back. A print request, and an enqueue that finds
// the queue full, keep busy high while the dump reads the first q slots,
// q being slot_count clamped to 2..DEPTH, through the single read port of
// the slot memory, one slot per cycle. Each result appears on kind, slot_value
// and last for exactly one cycle with strobe high, after the registered
// memory read and the output register; the receiver cannot hold results off,
// so it must take one result in every cycle that strobe is high. A dequeue
// on an empty queue gives one underflow notice through the same read stage
// and output register. After an overflow or underflow the block halts: requests
// are still taken but have no effect and give no result until reset. A write
// of slot_count keeps busy high while the front and rear indices are reduced
// into the new ring, one subtraction per cycle. Slot contents read as zero
// after reset through per-slot valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_queue_with_dump_core #(
	parameter int DEPTH = cqd_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  cqd_pkg::op_t                       operation,
	input  logic signed [cqd_pkg::VALUE_W-1:0] value,
	input  logic                               cfg_we,
	input  logic [cqd_pkg::SLOT_COUNT_W-1:0]   cfg_wdata,
	output logic                               strobe,
	output cqd_pkg::kind_t                     kind,
	output logic signed [cqd_pkg::VALUE_W-1:0] slot_value,
	output logic                               last
);
	import cqd_pkg::*;

	// Index width for the slot memory, and a compare width wide enough for
	// both the ring size and the slot_count register.
	localparam int IW  = $clog2(DEPTH);
	localparam int QW0 = $clog2(DEPTH + 1);
	localparam int CW  = (QW0 > SLOT_COUNT_W) ? QW0 : SLOT_COUNT_W;

	// Configuration and queue state. The raw indices hold the values last
	// written by a request; they are kept as they are across slot_count
	// changes. front_q and rear_q are working copies reduced into the ring.
	logic [SLOT_COUNT_W-1:0] slot_count_q;
	logic [IW-1:0]           front_raw_q;
	logic [IW-1:0]           rear_raw_q;
	logic [IW-1:0]           front_q;
	logic [IW-1:0]           rear_q;
	logic                    halted_q;
	logic                    norm_q;
	logic [DEPTH-1:0]        valid_q;

	// Dump sequencer.
	logic                    dump_q;
	logic [IW-1:0]           cnt_q;
	kind_t                   dkind_q;

	// Read stage: the memory data arrives while these are held.
	logic                    stb_s1;
	kind_t                   kind_s1;
	logic                    last_s1;
	logic                    live_s1;

	// Output registers.
	logic                    strobe_q;
	kind_t                   kind_q;
	logic [VALUE_W-1:0]      slot_value_q;
	logic                    last_q;

	// Ring arithmetic.
	logic [CW-1:0]           sc_ext;
	logic [CW-1:0]           q;
	logic [CW-1:0]           f_ext;
	logic [CW-1:0]           r_ext;
	logic [CW-1:0]           r_plus1;
	logic [CW-1:0]           r_inc;
	logic [CW-1:0]           r_plus2;
	logic [CW-1:0]           r_inc2;
	logic [CW-1:0]           f_plus1;
	logic [CW-1:0]           f_inc;
	logic                    full;
	logic                    empty;
	logic                    last_rd;

	// Request decode.
	logic                    accept;
	logic                    enq_ok;
	logic                    deq_ok;
	logic                    ovf;
	logic                    unf;
	logic                    prt;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic [VALUE_W-1:0]      wr_data;
	logic [VALUE_W-1:0]      rd_data;

	// The ring size is slot_count clamped to 2..DEPTH.
	assign sc_ext = CW'(slot_count_q);
	always_comb begin
		if (sc_ext < CW'(2)) begin
			q = CW'(2);
		end else if (sc_ext > CW'(DEPTH)) begin
			q = CW'(DEPTH);
		end else begin
			q = sc_ext;
		end
	end

	// Outside of normalization both indices are already below q, so a wrap
	// is a single compare against q.
	assign f_ext   = CW'(front_q);
	assign r_ext   = CW'(rear_q);
	assign r_plus1 = r_ext + CW'(1);
	assign r_inc   = (r_plus1 == q) ? '0 : r_plus1;
	assign r_plus2 = r_inc + CW'(1);
	assign r_inc2  = (r_plus2 == q) ? '0 : r_plus2;
	assign f_plus1 = f_ext + CW'(1);
	assign f_inc   = (f_plus1 == q) ? '0 : f_plus1;

	// One slot is always kept free: empty when rear is just behind front,
	// full when two behind.
	assign empty = (r_inc == f_ext);
	assign full  = (r_inc2 == f_ext);

	assign last_rd = (CW'(cnt_q) + CW'(1) == q);

	assign busy   = norm_q | dump_q;
	assign accept = start & ~busy;

	always_comb begin
		enq_ok  = 1'b0;
		deq_ok  = 1'b0;
		ovf     = 1'b0;
		unf     = 1'b0;
		prt     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (accept && !halted_q) begin
			unique case (operation)
				OP_ENQ: begin
					if (full) begin
						ovf = 1'b1;
					end else begin
						enq_ok  = 1'b1;
						wr_en   = 1'b1;
						wr_addr = r_inc[IW-1:0];
						wr_data = $unsigned(value);
					end
				end
				OP_DEQ: begin
					if (empty) begin
						unf = 1'b1;
					end else begin
						// The front slot is cleared as it is released.
						deq_ok  = 1'b1;
						wr_en   = 1'b1;
						wr_addr = front_q;
						wr_data = '0;
					end
				end
				OP_PRINT: begin
					prt = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	cqd_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (cnt_q),
		.rdata (rd_data)
	);

	// Control state. A slot_count write reloads the working indices from the
	// raw ones, which may lie beyond the new ring; they are brought back by
	// repeated subtraction of q while busy holds requests off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			front_raw_q  <= IW'(1);
			rear_raw_q   <= '0;
			front_q      <= IW'(1);
			rear_q       <= '0;
			halted_q     <= 1'b0;
			norm_q       <= 1'b0;
			valid_q      <= '0;
			dump_q       <= 1'b0;
			cnt_q        <= '0;
			dkind_q      <= KIND_PRINT;
			stb_s1       <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_wdata;
				norm_q       <= 1'b1;
				front_q      <= front_raw_q;
				rear_q       <= rear_raw_q;
			end else if (norm_q) begin
				if (f_ext >= q) begin
					front_q <= IW'(f_ext - q);
				end
				if (r_ext >= q) begin
					rear_q <= IW'(r_ext - q);
				end
				if (f_ext < q && r_ext < q) begin
					norm_q <= 1'b0;
				end
			end

			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (enq_ok) begin
				rear_q     <= r_inc[IW-1:0];
				rear_raw_q <= r_inc[IW-1:0];
			end
			if (deq_ok) begin
				front_q     <= f_inc[IW-1:0];
				front_raw_q <= f_inc[IW-1:0];
			end
			if (ovf || unf) begin
				halted_q <= 1'b1;
			end

			// The dump walks the slots from index zero, one read per cycle.
			if (ovf || prt) begin
				dump_q  <= 1'b1;
				cnt_q   <= '0;
				dkind_q <= ovf ? KIND_OVERFLOW : KIND_PRINT;
			end else if (dump_q) begin
				cnt_q <= cnt_q + IW'(1);
				if (last_rd) begin
					dump_q <= 1'b0;
				end
			end

			stb_s1   <= dump_q | unf;
			strobe_q <= stb_s1;
		end
	end

	// Result payload. A slot never written since reset reads as zero, and
	// the underflow notice carries zero as well.
	always_ff @(posedge clk) begin
		kind_s1      <= unf ? KIND_UNDERFLOW : dkind_q;
		last_s1      <= unf | last_rd;
		live_s1      <= dump_q & valid_q[cnt_q];
		kind_q       <= kind_s1;
		last_q       <= last_s1;
		slot_value_q <= live_s1 ? rd_data : '0;
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign slot_value = $signed(slot_value_q);
	assign last       = last_q;

`ifndef SYNTHESIS
	// Once halted, the block stays halted until reset.
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	// With no normalization pending, both indices lie inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		!norm_q |-> (f_ext < q) && (r_ext < q))
		else $error("queue index outside the ring");

	// An underflow notice is always a final result that carries zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_UNDERFLOW) |-> last && (slot_value == '0))
		else $error("malformed underflow notice");

	// A dump is never started while another dump is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> !(ovf || prt || unf))
		else $error("request decoded during a dump");
`endif

endmodule

// ===== rtl/cqd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/cqd_checker.sv =====
// ----------------------------------------------------------------------------
// Circular queue with dump: result checker
// Watches the request, configuration and result ports of the queue core,
// keeps its own copy of the ring and predicts every dump entry and underflow
// notice, then compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module cqd_checker #(
	parameter int DEPTH = cqd_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  cqd_pkg::op_t                       operation,
	input  logic signed [cqd_pkg::VALUE_W-1:0] value,
	input  logic                               cfg_we,
	input  logic [cqd_pkg::SLOT_COUNT_W-1:0]   cfg_wdata,
	input  logic                               strobe,
	input  cqd_pkg::kind_t                     kind,
	input  logic signed [cqd_pkg::VALUE_W-1:0] slot_value,
	input  logic                               last,
	output int                                 errors,
	output int                                 pending
);

	import cqd_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] data;
		logic               is_last;
	} dump_entry_t;

	dump_entry_t awaited_results[$];

	logic [VALUE_W-1:0]      slot_mirror [DEPTH];
	int unsigned             mirror_front = 1;
	int unsigned             mirror_rear  = 0;
	bit                      mirror_halted = 1'b0;
	logic [SLOT_COUNT_W-1:0] mirror_count = SLOT_COUNT_RST;
	int                      fail_count = 0;
	int                      result_num = 0;

	// A dump lists the first q slots in index order, the final one flagged.
	function automatic void push_dump(input int unsigned q, input kind_t k);
		for (int j = 0; j < q; j++)
			awaited_results.push_back('{kind: k, data: slot_mirror[j],
				is_last: (j + 1 == q)});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_mirror[i] = '0;
			mirror_front  = 1;
			mirror_rear   = 0;
			mirror_halted = 1'b0;
			mirror_count  = SLOT_COUNT_RST;
			awaited_results.delete();
		end else begin
			if (strobe) begin : compare_result
				dump_entry_t want;
				if (awaited_results.size() == 0) begin
					if (fail_count < 10)
						$display("[%0t] result %0d unexpected: kind=%0d value=%0d last=%0d",
							$realtime, result_num, kind, slot_value, last);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (want.kind !== kind || want.data !== slot_value ||
					    want.is_last !== last) begin
						if (fail_count < 10)
							$display({"[%0t] result %0d mismatch: expected kind=%0d ",
								"value=%0d last=%0d, got kind=%0d value=%0d last=%0d"},
								$realtime, result_num, want.kind, $signed(want.data),
								want.is_last, kind, slot_value, last);
						fail_count++;
					end
				end
				result_num++;
			end

			if (start && !busy && !mirror_halted) begin : predict_request
				int unsigned q, f, r;
				q = (mirror_count < 2) ? 2 : (mirror_count > DEPTH) ? DEPTH : mirror_count;
				f = mirror_front % q;
				r = mirror_rear % q;
				case (operation)
					OP_ENQ: begin
						if ((r + 2) % q == f) begin
							mirror_halted = 1'b1;
							push_dump(q, KIND_OVERFLOW);
						end else begin
							r = (r + 1) % q;
							slot_mirror[r] = value;
							mirror_rear = r;
						end
					end
					OP_DEQ: begin
						if ((r + 1) % q == f) begin
							mirror_halted = 1'b1;
							awaited_results.push_back('{kind: KIND_UNDERFLOW, data: '0,
								is_last: 1'b1});
						end else begin
							slot_mirror[f] = '0;
							mirror_front = (f + 1) % q;
						end
					end
					OP_PRINT: push_dump(q, KIND_PRINT);
					default: begin
					end
				endcase
			end

			if (cfg_we)
				mirror_count = cfg_wdata;
		end
		errors  <= fail_count;
		pending <= awaited_results.size();
	end

endmodule

// ===== tb/tb_circular_queue_with_dump_core.sv =====
// ----------------------------------------------------------------------------
// Circular queue with dump: testbench top
// Drives enqueue, dequeue and print requests and slot_count writes into the
// queue core, with a checker beside it that predicts every result. Ends with
// one overflow or one underflow, after which the core must stay silent.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_dump_core;

	import cqd_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	// Quiet cycles allowed before the run is declared hung. The longest
	// legitimate quiet stretch is a long idle gap, a settle wait or the
	// closing tail wait.
	localparam int STALL_LIMIT = 1000;
	// Cycles to let the core finish a request that gives no result.
	localparam int SETTLE      = 8;
	localparam int TAIL        = 2 * DEPTH;
	localparam int RANDOM_REQS = 200;

	// The one operation code the package leaves unnamed; the core ignores it.
	localparam op_t OP_UNUSED  = 2'd3;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      start     = 1'b0;
	op_t                       operation = OP_ENQ;
	logic signed [VALUE_W-1:0] value     = '0;
	logic                      cfg_we    = 1'b0;
	logic [SLOT_COUNT_W-1:0]   cfg_wdata = SLOT_COUNT_RST;
	logic                      busy;
	logic                      strobe;
	kind_t                     kind;
	logic signed [VALUE_W-1:0] slot_value;
	logic                      last;
	int                        mismatches;
	int                        outstanding;

	// Stimulus-side view of the ring indices. It only steers the request mix
	// so that the queue is neither overrun nor drained by accident before the
	// final error; the slot contents are the checker's business.
	int unsigned ring_q   = DEPTH;
	int unsigned head_pos = 1;
	int unsigned tail_pos = 0;
	bit          frozen   = 1'b0;
	bit          no_gaps  = 1'b0;

	circular_queue_with_dump_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.kind      (kind),
		.slot_value(slot_value),
		.last      (last)
	);

	cqd_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.kind      (kind),
		.slot_value(slot_value),
		.last      (last),
		.errors    (mismatches),
		.pending   (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The stored indices are reduced modulo the current ring size wherever
	// they are used, exactly as the core does after a slot_count change.
	function automatic bit ring_full();
		return ((tail_pos % ring_q) + 2) % ring_q == head_pos % ring_q;
	endfunction

	function automatic bit ring_empty();
		return ((tail_pos % ring_q) + 1) % ring_q == head_pos % ring_q;
	endfunction

	// Roughly one value in five is a corner of the signed 32-bit range.
	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(19))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Most gaps are absent or short, a few are long. In a phase with no_gaps
	// set the requests go back to back, so the core sees them the moment it
	// drops busy.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (no_gaps || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Presents one request and holds it until the core takes it. start is
	// left high on return; the next request either keeps it high or drops it
	// for a gap, so start never sees two assignments in one time step.
	task automatic issue(input op_t op, input logic [VALUE_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		value     <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (!frozen) begin
			case (op)
				OP_ENQ:  tail_pos = ((tail_pos % ring_q) + 1) % ring_q;
				OP_DEQ:  head_pos = ((head_pos % ring_q) + 1) % ring_q;
				default: begin
				end
			endcase
		end
	endtask

	// Stops sending and waits until every predicted result has come out,
	// then gives the core a settle wait for any trailing enqueue or
	// dequeue. The checker's count is registered, so it is read only after
	// the edge that follows the last request.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// slot_count may only change while the core is idle: drain first, and
	// let any index reduction from an earlier write finish.
	task automatic write_slot_count(input logic [SLOT_COUNT_W-1:0] n);
		wait_drained();
		while (busy)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ring_q = (n < 2) ? 2 : (n > DEPTH) ? DEPTH : n;
	endtask

	// Hang detection: a cycle counts as quiet when no request, result or
	// register write is taken.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || strobe || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int                      counted;
		int                      phase;
		int                      phase_len;
		int                      lean;
		int                      roll;
		op_t                     op;
		bit                      go_over;
		logic [SLOT_COUNT_W-1:0] n;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the reset size of 16 slots, a print must show
		// the cleared ring. The enqueued values include the corners of the signed
		// range, and the unused operation code must pass without effect.
		issue(OP_PRINT, rand_value());
		issue(OP_ENQ, 32'h7FFF_FFFF);
		issue(OP_ENQ, 32'h8000_0000);
		issue(OP_ENQ, 32'h0000_0000);
		issue(OP_ENQ, 32'hFFFF_FFFF);
		issue(OP_ENQ, 32'h0000_0001);
		issue(OP_UNUSED, rand_value());
		issue(OP_PRINT, rand_value());
		issue(OP_DEQ, rand_value());
		issue(OP_DEQ, rand_value());
		issue(OP_PRINT, rand_value());

		// A slot_count of zero clamps to the two-slot ring. The indices left
		// from the sixteen-slot ring are reduced, which here leaves the ring
		// full, and slots 2 and up must keep their contents unseen.
		write_slot_count('0);
		issue(OP_PRINT, rand_value());
		issue(OP_DEQ, rand_value());
		issue(OP_ENQ, rand_value());
		issue(OP_PRINT, rand_value());

		// All ones clamps back to the full depth; the upper slots reappear.
		write_slot_count('1);
		issue(OP_PRINT, rand_value());
		issue(OP_ENQ, rand_value());
		issue(OP_PRINT, rand_value());

		// Random part, in phases. Each phase starts with a drain and a new
		// slot_count, then a run of requests leaning toward filling or toward
		// emptying, so the ring keeps touching both its full and its empty
		// state without ever tripping an error.
		counted = 0;
		phase   = 0;
		while (counted < RANDOM_REQS) begin
			if (phase == 0)
				n = 5'd2;
			else if (phase == 1)
				n = SLOT_COUNT_W'(DEPTH);
			else if ($urandom_range(4) == 0) begin
				case ($urandom_range(5))
					0:       n = 5'd0;
					1:       n = 5'd1;
					2:       n = 5'd2;
					3:       n = SLOT_COUNT_W'(DEPTH);
					4:       n = SLOT_COUNT_W'(DEPTH + 1);
					default: n = '1;
				endcase
			end else
				n = SLOT_COUNT_W'($urandom_range(31));
			write_slot_count(n);
			no_gaps   = ($urandom_range(3) == 0);
			lean      = $urandom_range(20, 80);
			phase_len = $urandom_range(10, 40);
			repeat (phase_len) begin
				roll = $urandom_range(99);
				if (roll < 5)
					issue(OP_UNUSED, rand_value());
				else begin
					if (roll < 15)
						op = OP_PRINT;
					else if (ring_full())
						op = OP_DEQ;
					else if (ring_empty())
						op = OP_ENQ;
					else
						op = ($urandom_range(99) < lean) ? OP_ENQ : OP_DEQ;
					issue(op, rand_value());
					counted++;
				end
			end
			phase++;
		end

		// The core halts for good on its first error and reset comes only
		// once, so the run ends with a single overflow or underflow, chosen
		// at random.
		no_gaps = 1'b0;
		go_over = 1'($urandom_range(1));
		if (go_over) begin
			while (!ring_full())
				issue(OP_ENQ, rand_value());
		end else begin
			while (!ring_empty())
				issue(OP_DEQ, rand_value());
		end
		frozen = 1'b1;
		issue(go_over ? OP_ENQ : OP_DEQ, rand_value());

		// Once halted, every request is taken but must give nothing, and a
		// slot_count write must not wake the core.
		issue(OP_PRINT, rand_value());
		issue(OP_ENQ, rand_value());
		issue(OP_DEQ, rand_value());
		issue(OP_UNUSED, rand_value());
		write_slot_count(SLOT_COUNT_W'($urandom_range(31)));
		issue(OP_PRINT, rand_value());
		issue(OP_DEQ, rand_value());

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cqd_pkg.sv
rtl/cqd_ram.sv
rtl/circular_queue_with_dump_core.sv
tb/cqd_checker.sv
tb/tb_circular_queue_with_dump_core.sv
